// ===== hdl/fcsg_pkg.sv =====
// Shared types and constants for the filled circle span generator.
// Used by fcsg_ctrl, fcsg_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcsg_pkg;

    localparam int unsigned X_W      = 8;
    localparam int unsigned Y_W      = 10;
    localparam int unsigned R_W      = 5;
    localparam int unsigned COLOR_W  = 4;
    localparam int unsigned LEFT_W   = 9;
    localparam int unsigned ROW_W    = 11;
    localparam int unsigned WIDTH_W  = 6;
    localparam int unsigned DY_W     = R_W + 1;
    localparam int unsigned SQ_W     = 2 * R_W;

    localparam logic [Y_W-1:0] ROW_BASE_RESET = 10'd528;

    // root walker steps taken per cycle
    localparam int unsigned ADJ_STEPS = 4;

    typedef struct packed {
        logic load;   // capture input beat, start a new circle
        logic emit;   // push current row into output register, advance dy
    } fcsg_cmd_t;

    typedef struct packed {
        logic zero_radius;  // incoming beat has radius 0
        logic settled;      // half width for current row is final
        logic out_free;     // output register can take a beat this cycle
        logic last_row;     // current row is the final span of the circle
    } fcsg_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fcsg_ctrl.sv =====
// Controller for the filled circle span generator: idle/run state machine.
// Depends on fcsg_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fcsg_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  fcsg_pkg::fcsg_stat_t     stat,
    output fcsg_pkg::fcsg_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!stat.zero_radius) begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (stat.settled && stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last_row) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_load_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> !cmd.load)
        else $error("load issued while a circle is in progress");

    a_last_emit_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && stat.last_row) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after last span");

    a_zero_radius_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && stat.zero_radius) |=> (state_reg == S_IDLE))
        else $error("zero radius circle entered run state");

endmodule

`default_nettype wire

// ===== hdl/fcsg_datapath.sv =====
// Datapath for the filled circle span generator: row stepper, incremental
// integer square root walker, row_base register and output register. Uses fcsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcsg_datapath #(
    parameter int unsigned MAX_RADIUS = 31
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fcsg_pkg::Y_W-1:0]           cfg_wdata,
    input  wire logic [fcsg_pkg::X_W-1:0]           s_center_x,
    input  wire logic [fcsg_pkg::Y_W-1:0]           s_center_y,
    input  wire logic [fcsg_pkg::R_W-1:0]           s_radius,
    input  wire logic [fcsg_pkg::COLOR_W-1:0]       s_fill_color,
    input  fcsg_pkg::fcsg_cmd_t                     cmd,
    output fcsg_pkg::fcsg_stat_t                    stat,
    output logic signed [fcsg_pkg::LEFT_W-1:0]      m_span_left,
    output logic [fcsg_pkg::ROW_W-1:0]              m_span_row,
    output logic [fcsg_pkg::WIDTH_W-1:0]            m_span_width,
    output logic [fcsg_pkg::COLOR_W-1:0]            m_span_color,
    output logic                                    m_last_span,
    output logic                                    m_valid,
    input  wire logic                               m_ready
);

    localparam logic [fcsg_pkg::R_W-1:0] R_MAX = fcsg_pkg::R_W'(MAX_RADIUS);

    logic [fcsg_pkg::Y_W-1:0]      row_base_reg;
    logic [fcsg_pkg::X_W-1:0]      cx_reg;
    logic [fcsg_pkg::COLOR_W-1:0]  color_reg;
    logic [fcsg_pkg::R_W-1:0]      r_reg;
    logic [fcsg_pkg::DY_W-1:0]     dy_reg;     // two's complement row offset
    logic [fcsg_pkg::SQ_W-1:0]     n_reg;      // r^2 - dy^2
    logic [fcsg_pkg::ROW_W-1:0]    row_reg;
    logic [fcsg_pkg::R_W-1:0]      h_reg;
    logic [fcsg_pkg::SQ_W-1:0]     hsq_reg;    // h_reg^2

    logic [fcsg_pkg::LEFT_W-1:0]   left_reg;
    logic [fcsg_pkg::ROW_W-1:0]    out_row_reg;
    logic [fcsg_pkg::WIDTH_W-1:0]  width_reg;
    logic [fcsg_pkg::COLOR_W-1:0]  out_color_reg;
    logic                          last_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;

    logic [fcsg_pkg::R_W-1:0]      r_sat;
    logic [fcsg_pkg::R_W-1:0]      h_adj;
    logic [fcsg_pkg::SQ_W-1:0]     sq_adj;
    logic [fcsg_pkg::SQ_W:0]       sq_up;
    logic [fcsg_pkg::SQ_W+1:0]     n_step;

    assign r_sat = (s_radius > R_MAX) ? R_MAX : s_radius;

    // Walk h toward floor(sqrt(n)) a few unit steps at a time; the row
    // is held until the walk settles.
    always_comb begin
        logic [fcsg_pkg::SQ_W:0] nxt;
        h_adj  = h_reg;
        sq_adj = hsq_reg;
        for (int i = 0; i < fcsg_pkg::ADJ_STEPS; i++) begin
            nxt = {1'b0, sq_adj} + {{(fcsg_pkg::SQ_W-fcsg_pkg::R_W){1'b0}}, h_adj, 1'b0}
                + (fcsg_pkg::SQ_W+1)'(1);
            if (sq_adj > n_reg) begin
                sq_adj = sq_adj - ({{(fcsg_pkg::SQ_W-fcsg_pkg::R_W-1){1'b0}}, h_adj, 1'b0}
                         - fcsg_pkg::SQ_W'(1));
                h_adj  = h_adj - fcsg_pkg::R_W'(1);
            end else if (nxt <= {1'b0, n_reg}) begin
                sq_adj = nxt[fcsg_pkg::SQ_W-1:0];
                h_adj  = h_adj + fcsg_pkg::R_W'(1);
            end
        end
        sq_up = {1'b0, sq_adj} + {{(fcsg_pkg::SQ_W-fcsg_pkg::R_W){1'b0}}, h_adj, 1'b0}
              + (fcsg_pkg::SQ_W+1)'(1);
    end

    // n(dy+1) = n(dy) - (2*dy + 1)
    assign n_step = {2'b00, n_reg}
                  - {{(fcsg_pkg::SQ_W+1-fcsg_pkg::DY_W){dy_reg[fcsg_pkg::DY_W-1]}}, dy_reg, 1'b1};

    always_comb begin
        stat.zero_radius = (s_radius == '0);
        stat.settled     = (sq_adj <= n_reg) && (sq_up > {1'b0, n_reg});
        stat.out_free    = !m_valid_reg || m_ready;
        stat.last_row    = (dy_reg == {1'b0, r_reg - fcsg_pkg::R_W'(1)});
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_base_reg <= fcsg_pkg::ROW_BASE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                row_base_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg    <= s_center_x;
            color_reg <= s_fill_color;
            r_reg     <= r_sat;
            dy_reg    <= fcsg_pkg::DY_W'(1) - {1'b0, r_sat};
            n_reg     <= {{(fcsg_pkg::SQ_W-fcsg_pkg::R_W-1){1'b0}}, r_sat, 1'b0}
                         - fcsg_pkg::SQ_W'(1);
            row_reg   <= {1'b0, row_base_reg} + {1'b0, s_center_y} + fcsg_pkg::ROW_W'(1)
                         - {{(fcsg_pkg::ROW_W-fcsg_pkg::R_W){1'b0}}, r_sat};
            h_reg     <= '0;
            hsq_reg   <= '0;
        end else begin
            h_reg   <= h_adj;
            hsq_reg <= sq_adj;
            if (cmd.emit) begin
                dy_reg  <= dy_reg + fcsg_pkg::DY_W'(1);
                n_reg   <= n_step[fcsg_pkg::SQ_W-1:0];
                row_reg <= row_reg + fcsg_pkg::ROW_W'(1);
            end
        end
        if (cmd.emit) begin
            left_reg      <= {1'b0, cx_reg}
                             - {{(fcsg_pkg::LEFT_W-fcsg_pkg::R_W){1'b0}}, h_adj};
            out_row_reg   <= row_reg;
            width_reg     <= {h_adj, 1'b0};
            out_color_reg <= color_reg;
            last_reg      <= stat.last_row;
        end
    end

    assign m_span_left  = $signed(left_reg);
    assign m_span_row   = out_row_reg;
    assign m_span_width = width_reg;
    assign m_span_color = out_color_reg;
    assign m_last_span  = last_reg;
    assign m_valid      = m_valid_reg;

    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (h_adj != '0))
        else $error("span emitted with zero half width");

    a_emit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (sq_adj <= n_reg))
        else $error("half width squared exceeds r^2 - dy^2");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid_reg)
        else $error("output register not loaded after emit");

endmodule

`default_nettype wire

// ===== hdl/filled_circle_span_generator_top.sv =====
// Filled circle span generator: circle beat in, horizontal span beats out.
// Instantiates fcsg_ctrl and fcsg_datapath; uses fcsg_pkg.
//
// Input channel (s_*): one beat per circle with center x/y, radius and color.
// Output channel (m_*): one beat per span, rows in increasing order, the
// final span of a circle flagged by m_last_span. A circle of radius r
// (saturated to MAX_RADIUS) gives 2*r - 1 spans; radius 0 gives none.
// Config: cfg_we/cfg_wdata write row_base (reset 528). The user must
// write row_base only while idle; the block does not enforce this.
// Timing: after the input beat is taken, spans follow one per cycle
// when the receiver keeps up. The half-width walker moves up to four
// unit steps per cycle; a row whose root is farther off (the first row
// of a circle with r of 13 or more) is held until the walk settles.
// The first span is valid once the run state is entered, the walk has
// settled and the span is written into the output register.
// A one-beat output register decouples the sides: the next circle is
// taken as soon as the last span is in that register. When the receiver
// stalls, span generation stops and s_ready stays low until the circle
// finishes. Reset (aresetn low, synchronous) empties the output register,
// returns to idle and restores row_base.
`timescale 1ns / 1ps
`default_nettype none

module filled_circle_span_generator_top #(
    parameter int unsigned MAX_RADIUS = 31
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fcsg_pkg::Y_W-1:0]           cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [fcsg_pkg::X_W-1:0]           s_center_x,
    input  wire logic [fcsg_pkg::Y_W-1:0]           s_center_y,
    input  wire logic [fcsg_pkg::R_W-1:0]           s_radius,
    input  wire logic [fcsg_pkg::COLOR_W-1:0]       s_fill_color,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fcsg_pkg::LEFT_W-1:0]      m_span_left,
    output logic [fcsg_pkg::ROW_W-1:0]              m_span_row,
    output logic [fcsg_pkg::WIDTH_W-1:0]            m_span_width,
    output logic [fcsg_pkg::COLOR_W-1:0]            m_span_color,
    output logic                                    m_last_span
);

    fcsg_pkg::fcsg_cmd_t  cmd;
    fcsg_pkg::fcsg_stat_t stat;

    fcsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fcsg_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .s_fill_color (s_fill_color),
        .cmd          (cmd),
        .stat         (stat),
        .m_span_left  (m_span_left),
        .m_span_row   (m_span_row),
        .m_span_width (m_span_width),
        .m_span_color (m_span_color),
        .m_last_span  (m_last_span),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

`default_nettype wire
